// File: design/apq_pkg.sv
package apq_pkg;

	localparam int CAPACITY = 64;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);

	localparam logic MODE_ENQ = 1'b0;
	localparam logic MODE_DEQ = 1'b1;

	typedef enum logic [1:0] {
		ST_ENQ   = 2'd0,
		ST_DEQ   = 2'd1,
		ST_EMPTY = 2'd2,
		ST_FULL  = 2'd3
	} status_t;

	typedef struct packed {
		logic signed [31:0] value;
		logic signed [15:0] prio;
	} entry_t;

	typedef enum logic [1:0] {
		OP_HOLD,
		OP_NEXT,
		OP_LOAD
	} cell_op_t;

	typedef struct packed {
		logic             rotate;
		logic             shift;
		logic             write;
		logic [IDX_W-1:0] slot;
		logic [CNT_W-1:0] count;
		entry_t           data;
	} cell_cmd_t;

endpackage

// File: design/array_priority_queue_top.sv
// Priority queue of up to 64 (value, priority) entries held in a ring of cells in
// insertion order. An enqueue (tuser 0) presents its result in the cycle after
// acceptance; a full store returns status 3. A dequeue (tuser 1) rotates the whole
// ring once past a single comparator at the head cell, one cell per cycle, to find
// the highest priority (then larger value, then earliest entry), then closes the
// gap by shifting the cells from the removed slot onward once the result register
// is free, and registers its result with that shift; an empty store returns
// status 2 in the cycle after acceptance. One item is in work at a time,
// and a new one is accepted only while the result register is free or being taken.
// No clearing pass after reset.
module array_priority_queue_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic        s_tuser,   // mode
	input  logic [47:0] s_tdata,   // item_value[31:0], item_priority[47:32]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [1:0]  m_tuser,   // status
	output logic [47:0] m_tdata    // removed_value[31:0], removed_slot[37:32],
	                               // occupancy[44:38], zero fill[47:45]
);
	import apq_pkg::*;

	cell_cmd_t cmd;
	entry_t    cell_q [CAPACITY];

	apq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tuser  (s_tuser),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tuser  (m_tuser),
		.m_tdata  (m_tdata),
		.head     (cell_q[0]),
		.cmd      (cmd)
	);

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		cell_op_t op;

		always_comb begin
			if (cmd.rotate)
				op = OP_NEXT;
			else if (cmd.shift && (IDX_W'(i) >= cmd.slot))
				op = OP_NEXT;
			else if (cmd.write && (CNT_W'(i) == cmd.count))
				op = OP_LOAD;
			else
				op = OP_HOLD;
		end

		apq_cell u_cell (
			.clk (clk),
			.op  (op),
			.nxt (cell_q[(i + 1) % CAPACITY]),
			.din (cmd.data),
			.q   (cell_q[i])
		);
	end

endmodule

// File: design/apq_cell.sv
module apq_cell (
	input  logic              clk,
	input  apq_pkg::cell_op_t op,
	input  apq_pkg::entry_t   nxt,
	input  apq_pkg::entry_t   din,
	output apq_pkg::entry_t   q
);
	import apq_pkg::*;

	entry_t entry_q;

	always_ff @(posedge clk) begin
		case (op)
			OP_NEXT: entry_q <= nxt;
			OP_LOAD: entry_q <= din;
			default: entry_q <= entry_q;
		endcase
	end

	assign q = entry_q;

endmodule

// File: design/apq_ctrl.sv
module apq_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic               s_tuser,   // mode
	input  logic [47:0]        s_tdata,   // item_value[31:0], item_priority[47:32]
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [1:0]         m_tuser,   // status
	output logic [47:0]        m_tdata,   // removed_value[31:0], removed_slot[37:32],
	                                      // occupancy[44:38], zero fill[47:45]
	input  apq_pkg::entry_t    head,
	output apq_pkg::cell_cmd_t cmd
);
	import apq_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_DONE
	} state_t;

	localparam logic [IDX_W-1:0] LAST_STEP = IDX_W'(CAPACITY - 1);
	localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(CAPACITY);

	state_t           state_q;
	logic [CNT_W-1:0] count_q;
	logic [IDX_W-1:0] step_q;
	logic [IDX_W-1:0] best_slot_q;
	entry_t           best_q;
	logic             out_valid_q;
	status_t          out_status_q;
	logic [31:0]      out_value_q;
	logic [5:0]       out_slot_q;
	logic [6:0]       out_occ_q;

	logic   out_free;
	logic   out_load;
	logic   accept;
	logic   in_range;
	logic   better;
	logic   take;
	entry_t din;

	assign out_free = !out_valid_q || m_tready;
	assign s_tready = (state_q == S_IDLE) && out_free;
	assign accept   = s_tvalid && s_tready;
	assign out_load = (accept && ((s_tuser == MODE_ENQ) || (count_q == '0))) ||
	                  ((state_q == S_DONE) && out_free);

	assign din = {s_tdata[31:0], s_tdata[47:32]};

	assign in_range = CNT_W'(step_q) < count_q;
	assign better   = ($signed(head.prio) > $signed(best_q.prio)) ||
	                  (($signed(head.prio) == $signed(best_q.prio)) &&
	                   ($signed(head.value) > $signed(best_q.value)));
	assign take     = (step_q == '0) || (in_range && better);

	always_comb begin
		cmd        = '0;
		cmd.rotate = (state_q == S_SCAN);
		cmd.shift  = (state_q == S_DONE) && out_free;
		cmd.write  = accept && (s_tuser == MODE_ENQ) && (count_q < FULL_CNT);
		cmd.slot   = best_slot_q;
		cmd.count  = count_q;
		cmd.data   = din;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						out_value_q <= '0;
						out_slot_q  <= '0;
						if (s_tuser == MODE_ENQ) begin
							if (count_q < FULL_CNT) begin
								count_q      <= count_q + 1'b1;
								out_status_q <= ST_ENQ;
								out_occ_q    <= 7'(count_q + 1'b1);
							end else begin
								out_status_q <= ST_FULL;
								out_occ_q    <= 7'(count_q);
							end
						end else if (count_q == '0) begin
							out_status_q <= ST_EMPTY;
							out_occ_q    <= '0;
						end else begin
							step_q  <= '0;
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					if (take) begin
						best_q      <= head;
						best_slot_q <= step_q;
					end
					step_q <= step_q + 1'b1;
					if (step_q == LAST_STEP)
						state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						count_q      <= count_q - 1'b1;
						out_status_q <= ST_DEQ;
						out_value_q  <= best_q.value;
						out_slot_q   <= 6'(best_slot_q);
						out_occ_q    <= 7'(count_q - 1'b1);
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_status_q;
	assign m_tdata  = {3'b000, out_occ_q, out_slot_q, out_value_q};

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_CNT)
		else $error("entry count above capacity");

	a_scan_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN || state_q == S_DONE) |-> count_q != '0)
		else $error("removal pass with an empty store");

	a_empty_occ: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_status_q == ST_EMPTY) |-> out_occ_q == '0)
		else $error("empty result with nonzero occupancy");

	a_full_occ: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_status_q == ST_FULL) |-> out_occ_q == 7'(CAPACITY))
		else $error("full result with wrong occupancy");

	a_scan_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && accept && s_tuser == MODE_DEQ && count_q != '0)
		|=> state_q == S_SCAN && step_q == '0)
		else $error("removal pass did not start at the head");

endmodule
